FILE: rtl/qrgs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrgs_pkg
// Shared types and constants of the Gram-Schmidt QR unit.
// ---------------------------------------------------------------------------
package qrgs_pkg;

  // default sizes
  localparam int unsigned DEF_MAX_ROWS   = 4;
  localparam int unsigned DEF_MAX_COLS   = 4;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // element width in the stores and on the ports
  localparam int unsigned ELEM_W = 32;

  // configuration port
  localparam int unsigned CFG_W     = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  // iteration counts of the sqrt / divide unit
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 48;

  // input request payload
  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_value;
  } qrgs_item_t;

  // result payload
  typedef struct packed {
    logic                     which_matrix;
    logic [1:0]               out_row;
    logic [1:0]               out_col;
    logic signed [ELEM_W-1:0] out_value;
    logic                     degenerate;
    logic                     last_result;
  } qrgs_res_t;

  // sqrt / divide unit operation
  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } qrgs_op_e;

  typedef struct packed {
    logic     go;
    qrgs_op_e op;
  } qrgs_iter_req_t;

  typedef struct packed {
    logic done;
  } qrgs_iter_rsp_t;

endpackage

FILE: rtl/qrgs_stream_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrgs_stream_if
// Valid/ready channel carrying one payload per request.
// ---------------------------------------------------------------------------
interface qrgs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/qrgs_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrgs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module qrgs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/qrgs_iter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrgs_iter
// Shared iterative unit: 64-bit integer square root (one result bit per
// cycle) and 48-bit by 32-bit restoring division (one quotient bit per cycle).
// ---------------------------------------------------------------------------
module qrgs_iter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  qrgs_pkg::qrgs_iter_req_t req_i,
  input  logic [63:0]              opa_i,
  input  logic [31:0]              den_i,
  output qrgs_pkg::qrgs_iter_rsp_t rsp_o,
  output logic [63:0]              result_o
);
  import qrgs_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  qrgs_op_e    op_q, op_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] v_q, v_d;       // sqrt remainder
  logic [63:0] r_q, r_d;       // root or quotient
  logic [63:0] bit_q, bit_d;   // sqrt trial bit
  logic [31:0] rem_q, rem_d;   // division remainder
  logic [47:0] num_q, num_d;   // dividend, shifted out msb first
  logic [31:0] den_q, den_d;

  logic [63:0] trial;
  logic [32:0] rem_n;

  assign trial = r_q + bit_q;
  assign rem_n = {rem_q, num_q[47]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;

    if (req_i.go) begin
      // start a new operation
      busy_d = 1'b1;
      op_d   = req_i.op;
      r_d    = '0;
      v_d    = opa_i;
      bit_d  = 64'd1 << 62;
      num_d  = opa_i[47:0];
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = (req_i.op == OP_SQRT) ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
    end else if (busy_q) begin
      case (op_q)
        OP_SQRT: begin
          if (v_q >= trial) begin
            v_d = v_q - trial;
            r_d = (r_q >> 1) + bit_q;
          end else begin
            r_d = r_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
        OP_DIV: begin
          if (rem_n >= {1'b0, den_q}) begin
            rem_d = 32'(rem_n - {1'b0, den_q});
            r_d   = {r_q[62:0], 1'b1};
          end else begin
            rem_d = rem_n[31:0];
            r_d   = {r_q[62:0], 1'b0};
          end
          num_d = {num_q[46:0], 1'b0};
        end
        default: ;
      endcase
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_SQRT;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign result_o   = r_q;

endmodule

FILE: rtl/qr_decomposition_gram_schmidt_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qr_decomposition_gram_schmidt_unit
// Classical Gram-Schmidt QR of an n x m Q16.16 matrix: loads X row-major,
// builds Q column by column in a RAM, then streams Q and R = Q^T X.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Contents
// in_i      in   valid/ready        elem_value, one element of X
// out_o     out  valid/ready        which_matrix, out_row, out_col, out_value,
//                                   degenerate, last_result
// cfg       in   cfg_we_i (no wait) cfg_idx_i: 0 rows, 1 cols; cfg_data_i
//
// Loading accepts one element per cycle (n*m requests), ready only while loading.
// Per Q column c: c projections (dot product, then accumulate), the residual,
// scaling, the squared norm, the root, and a divide for each of the n rows.
// Then Q streams, and each R element is recomputed as a dot product;
// all steps run through the one read port of each store and the shared
// sqrt/divide unit. A stalled output holds the sequencer. No clearing pass.
// ---------------------------------------------------------------------------
module qr_decomposition_gram_schmidt_unit #(
  parameter int unsigned MAX_ROWS   = qrgs_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS   = qrgs_pkg::DEF_MAX_COLS,
  parameter int unsigned DATA_WIDTH = qrgs_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qrgs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [qrgs_pkg::CFG_W-1:0]       cfg_data_i,
  qrgs_stream_if.sink                      in_i,
  qrgs_stream_if.source                    out_o
);
  import qrgs_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned SW    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SW - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  typedef enum logic [11:0] {
    S_LOAD  = 12'b0000_0000_0001,
    S_COL   = 12'b0000_0000_0010,
    S_IP    = 12'b0000_0000_0100,
    S_PACC  = 12'b0000_0000_1000,
    S_RES   = 12'b0000_0001_0000,
    S_SHIFT = 12'b0000_0010_0000,
    S_NORM  = 12'b0000_0100_0000,
    S_SQRT  = 12'b0000_1000_0000,
    S_DIV   = 12'b0001_0000_0000,
    S_ZERO  = 12'b0010_0000_0000,
    S_EQ    = 12'b0100_0000_0000,
    S_ROUT  = 12'b1000_0000_0000
  } state_e;

  // helpers
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] shr_round16(input logic signed [63:0] v);
    logic [63:0] m;
    m = (mag64(v) + 64'd32768) >> 16;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [ELEM_W-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > SAT_HI) r = SAT_HI;
    else if (v < SAT_LO) r = SAT_LO;
    else r = v;
    return r[ELEM_W-1:0];
  endfunction

  function automatic logic [AW-1:0] addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    logic [AW:0] a;
    a = (AW + 1)'(r) * (AW + 1)'(MAX_COLS) + (AW + 1)'(c);
    return a[AW-1:0];
  endfunction

  // registers
  state_e             state_q, state_d;
  logic [CFG_W-1:0]   rows_q, rows_d, cols_q, cols_d;
  logic [RW-1:0]      ld_r_q, ld_r_d, k_q, k_d;
  logic [CW-1:0]      ld_c_q, ld_c_d, j_q, j_d, c_q, c_d;
  logic [1:0]         ph_q, ph_d;
  logic               err_q, err_d;
  logic               emit_r_q, emit_r_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [39:0] ip_q, ip_d;
  logic signed [63:0] work_q [MAX_ROWS];
  logic signed [63:0] work_d [MAX_ROWS];
  logic [63:0]        maxm_q, maxm_d, msh_q, msh_d, nsq_q, nsq_d;
  logic [5:0]         s_q, s_d;
  logic [31:0]        nrm_q, nrm_d;
  logic               ovalid_q, ovalid_d;
  qrgs_res_t          ores_q, ores_d;

  // effective shape
  logic [3:0]    n_eff, m_eff;
  logic [RW-1:0] n_last;
  logic [CW-1:0] m_last;

  always_comb begin
    if (rows_q == '0) n_eff = 4'd1;
    else if (rows_q > MAX_ROWS) n_eff = 4'(MAX_ROWS);
    else n_eff = {1'b0, rows_q};
    if (cols_q == '0) m_eff = 4'd1;
    else if (cols_q > MAX_COLS) m_eff = 4'(MAX_COLS);
    else m_eff = {1'b0, cols_q};
  end
  assign n_last = RW'(n_eff - 4'd1);
  assign m_last = CW'(m_eff - 4'd1);

  // stores
  logic              x_we, x_re, q_we, q_re;
  logic [AW-1:0]     x_waddr, q_waddr, q_raddr;
  logic [ELEM_W-1:0] x_wdata, q_wdata, x_rdata, q_rdata;

  qrgs_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_xram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (x_waddr),
    .wdata_i (x_wdata),
    .re_i    (x_re),
    .raddr_i (addr(k_q, c_q)),
    .rdata_o (x_rdata)
  );

  qrgs_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_qram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // sqrt / divide unit
  qrgs_iter_req_t iter_req;
  qrgs_iter_rsp_t iter_rsp;
  logic [63:0]    iter_opa, iter_res;

  qrgs_iter u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (iter_req),
    .opa_i    (iter_opa),
    .den_i    (nrm_q),
    .rsp_o    (iter_rsp),
    .result_o (iter_res)
  );

  // datapath terms
  logic signed [ELEM_W-1:0] q_s, x_s;
  logic signed [17:0]       q18;
  logic signed [63:0]       p_dot, p_prj, res_val, acc_n, x64;
  logic [63:0]              res_mag, amag, ash;
  logic [59:0]              p_sq;
  logic                     out_free, in_acc, k_last;

  assign q_s     = $signed(q_rdata);
  assign x_s     = $signed(x_rdata);
  assign q18     = q_s[17:0];
  assign p_dot   = q_s * x_s;
  assign p_prj   = ip_q * q18;
  assign x64     = {{(64 - ELEM_W){x_s[ELEM_W-1]}}, x_s};
  assign res_val = shr_round16((x64 <<< 16) - work_q[k_q]);
  assign res_mag = mag64(res_val);
  assign amag    = mag64(work_q[k_q]);
  assign ash     = amag >> s_q;
  assign p_sq    = amag[29:0] * amag[29:0];
  assign acc_n   = acc_q + prod_q;
  assign out_free = !ovalid_q || out_o.ready;
  assign in_acc   = in_i.valid && in_i.ready;
  assign k_last   = (k_q == n_last);
  assign in_i.ready = (state_q == S_LOAD);

  // sequencer
  always_comb begin
    state_d  = state_q;
    rows_d   = rows_q;
    cols_d   = cols_q;
    ld_r_d   = ld_r_q;
    ld_c_d   = ld_c_q;
    k_d      = k_q;
    j_d      = j_q;
    c_d      = c_q;
    ph_d     = ph_q;
    err_d    = err_q;
    emit_r_d = emit_r_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    ip_d     = ip_q;
    work_d   = work_q;
    maxm_d   = maxm_q;
    msh_d    = msh_q;
    nsq_d    = nsq_q;
    s_d      = s_q;
    nrm_d    = nrm_q;
    ores_d   = ores_q;
    ovalid_d = ovalid_q && !out_o.ready;
    x_we     = 1'b0;
    x_waddr  = addr(ld_r_q, ld_c_q);
    x_wdata  = sat({{(64 - ELEM_W){in_i.payload.elem_value[ELEM_W-1]}},
                    in_i.payload.elem_value});
    x_re     = 1'b0;
    q_we     = 1'b0;
    q_waddr  = addr(k_q, c_q);
    q_wdata  = '0;
    q_re     = 1'b0;
    q_raddr  = (state_q == S_EQ) ? addr(k_q, c_q) : addr(k_q, j_q);
    iter_req.go = 1'b0;
    iter_req.op = OP_SQRT;
    iter_opa    = nsq_q;

    case (state_q)
      // load X, one element per request
      S_LOAD: begin
        if (in_acc) begin
          x_we = 1'b1;
          if (ld_r_q == n_last && ld_c_q == m_last) begin
            ld_r_d   = '0;
            ld_c_d   = '0;
            err_d    = (m_eff > n_eff);
            c_d      = '0;
            emit_r_d = 1'b0;
            state_d  = S_COL;
          end else if (ld_c_q == m_last) begin
            ld_c_d = '0;
            ld_r_d = ld_r_q + RW'(1);
          end else begin
            ld_c_d = ld_c_q + CW'(1);
          end
        end
      end
      // start of a Q column
      S_COL: begin
        k_d  = '0;
        ph_d = '0;
        if (int'(c_q) >= int'(n_eff)) begin
          state_d = S_ZERO;
        end else begin
          for (int i = 0; i < MAX_ROWS; i++) work_d[i] = '0;
          j_d     = '0;
          acc_d   = '0;
          maxm_d  = '0;
          state_d = (c_q == '0) ? S_RES : S_IP;
        end
      end
      // dot product of Q column j and X column c
      S_IP: begin
        case (ph_q)
          2'd0: begin
            q_re = 1'b1;
            x_re = 1'b1;
            ph_d = 2'd1;
          end
          2'd1: begin
            prod_d = p_dot;
            ph_d   = 2'd2;
          end
          default: begin
            ph_d = '0;
            if (k_last) begin
              ip_d    = 40'(shr_round16(acc_n));
              k_d     = '0;
              state_d = emit_r_q ? S_ROUT : S_PACC;
            end else begin
              acc_d = acc_n;
              k_d   = k_q + RW'(1);
            end
          end
        endcase
      end
      // projection accumulate: work[k] += ip * Q[k][j]
      S_PACC: begin
        case (ph_q)
          2'd0: begin
            q_re = 1'b1;
            ph_d = 2'd1;
          end
          2'd1: begin
            prod_d = p_prj;
            ph_d   = 2'd2;
          end
          default: begin
            ph_d         = '0;
            work_d[k_q]  = work_q[k_q] + prod_q;
            if (k_last) begin
              k_d = '0;
              if (({1'b0, j_q} + (CW + 1)'(1)) == {1'b0, c_q}) begin
                state_d = S_RES;
              end else begin
                j_d     = j_q + CW'(1);
                acc_d   = '0;
                state_d = S_IP;
              end
            end else begin
              k_d = k_q + RW'(1);
            end
          end
        endcase
      end
      // residual and its largest magnitude
      S_RES: begin
        if (ph_q == 2'd0) begin
          x_re = 1'b1;
          ph_d = 2'd1;
        end else begin
          ph_d        = '0;
          work_d[k_q] = res_val;
          maxm_d      = (res_mag > maxm_q) ? res_mag : maxm_q;
          if (k_last) begin
            k_d     = '0;
            msh_d   = maxm_d;
            s_d     = '0;
            state_d = S_SHIFT;
          end else begin
            k_d = k_q + RW'(1);
          end
        end
      end
      // find the scale-down shift
      S_SHIFT: begin
        if (|msh_q[63:30]) begin
          msh_d = msh_q >> 1;
          s_d   = s_q + 6'd1;
        end else begin
          nsq_d   = '0;
          state_d = S_NORM;
        end
      end
      // scale residuals and sum squares
      S_NORM: begin
        case (ph_q)
          2'd0: begin
            work_d[k_q] = work_q[k_q][63] ? -$signed(ash) : $signed(ash);
            ph_d        = 2'd1;
          end
          2'd1: begin
            prod_d = $signed({4'b0, p_sq});
            ph_d   = 2'd2;
          end
          default: begin
            ph_d  = '0;
            nsq_d = nsq_q + 64'(prod_q);
            if (k_last) begin
              k_d     = '0;
              state_d = S_SQRT;
            end else begin
              k_d = k_q + RW'(1);
            end
          end
        endcase
      end
      // integer root of the squared norm
      S_SQRT: begin
        if (ph_q == 2'd0) begin
          iter_req.go = 1'b1;
          ph_d        = 2'd1;
        end else if (iter_rsp.done) begin
          nrm_d = iter_res[31:0];
          if (iter_res[31:0] == '0) err_d = 1'b1;
          ph_d    = '0;
          state_d = S_DIV;
        end
      end
      // normalize into the Q store, or write zeros when the norm is zero or c >= n
      S_DIV, S_ZERO: begin
        iter_req.op = OP_DIV;
        iter_opa    = {18'b0, amag[29:0], 16'b0} + {33'b0, nrm_q[31:1]};
        if (state_q == S_ZERO || nrm_q == '0) begin
          q_we = 1'b1;
        end else if (ph_q == 2'd0) begin
          iter_req.go = 1'b1;
          ph_d        = 2'd1;
        end else if (iter_rsp.done) begin
          q_we    = 1'b1;
          q_wdata = work_q[k_q][63] ? 32'(-$signed(iter_res[31:0])) : iter_res[31:0];
        end
        if (q_we) begin
          ph_d = '0;
          if (k_last) begin
            k_d = '0;
            if (c_q == m_last) begin
              c_d     = '0;
              state_d = S_EQ;
            end else begin
              c_d     = c_q + CW'(1);
              state_d = S_COL;
            end
          end else begin
            k_d = k_q + RW'(1);
          end
        end
      end
      // stream Q row-major
      S_EQ: begin
        if (ph_q == 2'd0) begin
          q_re = 1'b1;
          ph_d = 2'd1;
        end else if (out_free) begin
          ovalid_d = 1'b1;
          ores_d.which_matrix = 1'b0;
          ores_d.out_row      = 2'(k_q);
          ores_d.out_col      = 2'(c_q);
          ores_d.out_value    = sat({{(64 - ELEM_W){q_s[ELEM_W-1]}}, q_s});
          ores_d.degenerate   = err_q;
          ores_d.last_result  = 1'b0;
          ph_d = '0;
          if (c_q == m_last) begin
            c_d = '0;
            if (k_last) begin
              k_d      = '0;
              j_d      = '0;
              acc_d    = '0;
              emit_r_d = 1'b1;
              state_d  = S_IP;
            end else begin
              k_d = k_q + RW'(1);
            end
          end else begin
            c_d = c_q + CW'(1);
          end
        end
      end
      // emit one R element, R[j][c]
      S_ROUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ores_d.which_matrix = 1'b1;
          ores_d.out_row      = 2'(j_q);
          ores_d.out_col      = 2'(c_q);
          ores_d.out_value    = sat({{24{ip_q[39]}}, ip_q});
          ores_d.degenerate   = err_q;
          ores_d.last_result  = (j_q == m_last) && (c_q == m_last);
          acc_d = '0;
          k_d   = '0;
          ph_d  = '0;
          state_d = S_IP;
          if (c_q == m_last) begin
            c_d = '0;
            if (j_q == m_last) begin
              j_d      = '0;
              err_d    = 1'b0;
              emit_r_d = 1'b0;
              state_d  = S_LOAD;
            end else begin
              j_d = j_q + CW'(1);
            end
          end else begin
            c_d = c_q + CW'(1);
          end
        end
      end
      default: state_d = S_LOAD;
    endcase

    // register writes reset the load position and the error flag
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS: rows_d = cfg_data_i;
        CFG_COLS: cols_d = cfg_data_i;
        default:  ;
      endcase
      ld_r_d = '0;
      ld_c_d = '0;
      err_d  = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      rows_q   <= CFG_W'(4);
      cols_q   <= CFG_W'(4);
      ld_r_q   <= '0;
      ld_c_q   <= '0;
      k_q      <= '0;
      j_q      <= '0;
      c_q      <= '0;
      ph_q     <= '0;
      err_q    <= 1'b0;
      emit_r_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rows_q   <= rows_d;
      cols_q   <= cols_d;
      ld_r_q   <= ld_r_d;
      ld_c_q   <= ld_c_d;
      k_q      <= k_d;
      j_q      <= j_d;
      c_q      <= c_d;
      ph_q     <= ph_d;
      err_q    <= err_d;
      emit_r_q <= emit_r_d;
      ovalid_q <= ovalid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
    ip_q   <= ip_d;
    work_q <= work_d;
    maxm_q <= maxm_d;
    msh_q  <= msh_d;
    nsq_q  <= nsq_d;
    s_q    <= s_d;
    nrm_q  <= nrm_d;
    ores_q <= ores_d;
  end

  assign out_o.valid   = ovalid_q;
  assign out_o.payload = ores_q;

endmodule
